### rtl/assert_macros.svh
// Assertion macros shared by the slot pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define OQSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define OQSP_NEVER(label, clk, rst, expr, msg) \
   `OQSP_ASSERT(label, clk, rst, !(expr), msg)

`else

`define OQSP_ASSERT(label, clk, rst, prop, msg)
`define OQSP_NEVER(label, clk, rst, expr, msg)

`endif

`endif

### rtl/oqsp_pkg.sv
// Types, codes and constants of the occlusion query slot pool.
package oqsp_pkg;

   localparam int SLOTS_DEF  = 64;
   localparam int WORD_W     = 32;
   localparam int FUNC_W     = 3;
   localparam int SLOT_IDX_W = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT   = 2'd1;

   typedef enum logic [FUNC_W-1:0] {
      FN_ALLOC     = 3'd0,
      FN_ISSUE     = 3'd1,
      FN_SUBMIT    = 3'd2,
      FN_FREE_SLOT = 3'd3,
      FN_FREE_OBJ  = 3'd4,
      FN_QUERY     = 3'd5,
      FN_NEW_FRAME = 3'd6,
      FN_CLEAR     = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_FREE    = 2'd0,
      PH_PENDING = 2'd1,
      PH_READY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE  = 2'd0,
      SQ_SCAN  = 2'd1,
      SQ_READ  = 2'd2,
      SQ_APPLY = 2'd3
   } seq_state_type;

   // Per-slot record kept in the record RAM
   typedef struct packed {
      phase_type         phase;
      logic              visible;
      logic [WORD_W-1:0] samples;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   // Event counter strobes from the sequencer
   typedef struct packed {
      logic inc_issue;
      logic inc_result;
      logic inc_visible;
      logic inc_occluded;
      logic clr_frame;
      logic clr_all;
   } evcnt_ctl_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_issued;
      logic [WORD_W-1:0] frame_results;
      logic [WORD_W-1:0] issued_total;
      logic [WORD_W-1:0] results_total;
      logic [WORD_W-1:0] visible_total;
      logic [WORD_W-1:0] occluded_total;
   } evcnt_val_type;

   // Per-beat result fields held in the output register
   typedef struct packed {
      status_type            status;
      logic [SLOT_IDX_W-1:0] granted;
      logic                  visible;
      logic [WORD_W-1:0]     samples;
   } res_type;

endpackage

### rtl/oqsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oqsp_ram #(
   parameter int WIDTH = oqsp_pkg::WORD_W,
   parameter int DEPTH = oqsp_pkg::SLOTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/oqsp_evcnt.sv
// Frame and total event counters of the slot pool.
`include "assert_macros.svh"

module oqsp_evcnt (
   input  logic                    clock,
   input  logic                    reset,
   input  oqsp_pkg::evcnt_ctl_type ev,
   output oqsp_pkg::evcnt_val_type cnt
);

   import oqsp_pkg::*;

   evcnt_val_type cnt_ff;
   evcnt_val_type cnt_in;

   // Advance or drop the counters on the sequencer's strobes
   always_comb begin
      cnt_in = cnt_ff;
      if (ev.clr_all) begin
         cnt_in = '0;
      end else begin
         if (ev.clr_frame) begin
            cnt_in.frame_issued  = '0;
            cnt_in.frame_results = '0;
         end
         if (ev.inc_issue) begin
            cnt_in.frame_issued = cnt_ff.frame_issued + WORD_W'(1);
            cnt_in.issued_total = cnt_ff.issued_total + WORD_W'(1);
         end
         if (ev.inc_result) begin
            cnt_in.frame_results = cnt_ff.frame_results + WORD_W'(1);
            cnt_in.results_total = cnt_ff.results_total + WORD_W'(1);
         end
         if (ev.inc_visible) begin
            cnt_in.visible_total = cnt_ff.visible_total + WORD_W'(1);
         end
         if (ev.inc_occluded) begin
            cnt_in.occluded_total = cnt_ff.occluded_total + WORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt = cnt_ff;

   // Every result is judged either visible or occluded
   `OQSP_ASSERT(a_result_split, clock, reset, WORD_W'(cnt_ff.visible_total + cnt_ff.occluded_total) == cnt_ff.results_total, "result totals disagree")
   `OQSP_NEVER(a_visible_and_occluded, clock, reset, ev.inc_visible && ev.inc_occluded, "result counted twice")

endmodule

### rtl/oqsp_ctrl.sv
// Sequencer of the slot pool: slot scan over the object RAM, shared compare, slot update.
`include "assert_macros.svh"

module oqsp_ctrl #(
   parameter int SLOTS = oqsp_pkg::SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [oqsp_pkg::FUNC_W-1:0]         func,
   input  logic [oqsp_pkg::WORD_W-1:0]         object_id,
   input  logic [oqsp_pkg::SLOT_IDX_W-1:0]     slot_index,
   input  logic [oqsp_pkg::WORD_W-1:0]         samples,
   input  logic [oqsp_pkg::WORD_W-1:0]         threshold,
   input  logic                                dflt,
   input  logic                                out_free,
   output logic                                busy,
   output logic                                done,
   output oqsp_pkg::res_type                   res,
   output oqsp_pkg::evcnt_ctl_type             ev,
   output logic [oqsp_pkg::COUNT_W-1:0]        in_use_count
);

   import oqsp_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam logic [SCAN_W-1:0]     SCAN_END  = SCAN_W'(SLOTS);
   localparam logic [SLOT_IDX_W:0]   SLOTS_EXT = (SLOT_IDX_W + 1)'(SLOTS);

   seq_state_type          state_ff, state_in;
   func_type               func_ff, func_in;
   logic [WORD_W-1:0]      obj_ff, obj_in;
   logic [WORD_W-1:0]      samp_ff, samp_in;
   logic [SLOT_W-1:0]      tgt_ff, tgt_in;
   status_type             status_ff, status_in;
   logic                   alloc_new_ff, alloc_new_in;
   logic [SCAN_W-1:0]      scan_ptr_ff, scan_ptr_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]      cmp_ptr_ff, cmp_ptr_in;
   logic                   free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0]      free_ptr_ff, free_ptr_in;
   logic [SLOTS-1:0]       taken_ff, taken_in;
   logic [SLOTS-1:0]       rec_vld_ff, rec_vld_in;
   logic                   wipe_vis_ff, wipe_vis_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic [WORD_W-1:0]      obj_rd_data;
   logic                   obj_wr_en;
   logic                   scan_rd;
   logic [REC_W-1:0]       rec_rd_data;
   logic                   rec_rd_en;
   logic                   rec_wr_en;
   slot_rec_type           rec_wr_data;
   slot_rec_type           rec_cur;
   slot_rec_type           rec_wiped;
   logic [WORD_W-1:0]      cmp_a;
   logic [WORD_W-1:0]      cmp_b;
   logic                   cmp_eq;
   logic                   cmp_gt;
   logic                   cmp_taken;
   logic                   hit;
   logic                   ok;

   // Object id of each slot; read slot by slot during the scan, taken or not
   oqsp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (obj_ff),
      .rd_en   (scan_rd),
      .rd_addr (scan_ptr_ff[SLOT_W-1:0]),
      .rd_data (obj_rd_data)
   );

   // Phase, samples and visibility of each slot
   oqsp_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (tgt_ff),
      .rd_data (rec_rd_data)
   );

   // Shared compare unit: object match during the scan, threshold on submit
   assign cmp_a  = (state_ff == SQ_SCAN) ? obj_rd_data : samp_ff;
   assign cmp_b  = (state_ff == SQ_SCAN) ? obj_ff : threshold;
   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_gt = (cmp_a > cmp_b);

   assign scan_rd   = (state_ff == SQ_SCAN) && (scan_ptr_ff < SCAN_END);
   assign cmp_taken = taken_ff[cmp_ptr_ff];
   assign hit       = cmp_vld_ff && cmp_taken && cmp_eq;
   assign ok        = (status_ff == ST_OK);

   // Record of the target slot; an entry never written since clear reads as wiped
   always_comb begin
      if (rec_vld_ff[tgt_ff]) begin
         rec_cur = slot_rec_type'(rec_rd_data);
      end else begin
         rec_cur.phase   = PH_FREE;
         rec_cur.visible = wipe_vis_ff;
         rec_cur.samples = '0;
      end
      rec_wiped.phase   = PH_FREE;
      rec_wiped.visible = dflt;
      rec_wiped.samples = '0;
   end

   // Next state, slot updates and result
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      obj_in       = obj_ff;
      samp_in      = samp_ff;
      tgt_in       = tgt_ff;
      status_in    = status_ff;
      alloc_new_in = alloc_new_ff;
      scan_ptr_in  = scan_ptr_ff;
      cmp_vld_in   = 1'b0;
      cmp_ptr_in   = scan_ptr_ff[SLOT_W-1:0];
      free_ok_in   = free_ok_ff;
      free_ptr_in  = free_ptr_ff;
      taken_in     = taken_ff;
      rec_vld_in   = rec_vld_ff;
      wipe_vis_in  = wipe_vis_ff;
      count_in     = count_ff;
      obj_wr_en    = 1'b0;
      rec_wr_en    = 1'b0;
      rec_wr_data  = rec_wiped;
      rec_rd_en    = 1'b0;
      done         = 1'b0;
      ev           = '0;
      res.status   = status_ff;
      res.granted  = '0;
      res.visible  = 1'b0;
      res.samples  = '0;

      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               func_in      = func_type'(func);
               obj_in       = object_id;
               samp_in      = samples;
               tgt_in       = slot_index[SLOT_W-1:0];
               status_in    = ST_OK;
               alloc_new_in = 1'b0;
               scan_ptr_in  = '0;
               free_ok_in   = 1'b0;
               unique case (func_type'(func))
                  FN_ALLOC, FN_FREE_OBJ, FN_QUERY: begin
                     state_in = SQ_SCAN;
                  end
                  FN_ISSUE, FN_SUBMIT, FN_FREE_SLOT: begin
                     // Ignore a slot beyond the pool
                     if ({1'b0, slot_index} >= SLOTS_EXT) begin
                        status_in = ST_MISS;
                        state_in  = SQ_APPLY;
                     end else if (func_type'(func) == FN_ISSUE) begin
                        state_in = SQ_READ;
                     end else begin
                        state_in = SQ_APPLY;
                     end
                  end
                  FN_NEW_FRAME, FN_CLEAR: begin
                     state_in = SQ_APPLY;
                  end
               endcase
            end
         end

         SQ_SCAN: begin
            // Advance the read pointer; stop feeding the compare on a hit
            if (scan_rd) begin
               scan_ptr_in = scan_ptr_ff + SCAN_W'(1);
               cmp_vld_in  = !hit;
            end
            // Remember the lowest untaken slot
            if (cmp_vld_ff && !cmp_taken && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_ptr_in = cmp_ptr_ff;
            end
            priority if (hit) begin
               tgt_in   = cmp_ptr_ff;
               state_in = (func_ff == FN_QUERY) ? SQ_READ : SQ_APPLY;
            end else if (!scan_rd && !cmp_vld_ff) begin
               state_in = SQ_APPLY;
               if (func_ff == FN_ALLOC) begin
                  if (free_ok_ff) begin
                     tgt_in       = free_ptr_ff;
                     alloc_new_in = 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else begin
                  status_in = ST_MISS;
               end
            end
         end

         SQ_READ: begin
            rec_rd_en = 1'b1;
            state_in  = SQ_APPLY;
         end

         SQ_APPLY: begin
            // Result fields
            unique case (func_ff)
               FN_ALLOC, FN_ISSUE, FN_SUBMIT, FN_FREE_SLOT, FN_FREE_OBJ: begin
                  if (ok) begin
                     res.granted = SLOT_IDX_W'(tgt_ff);
                  end
               end
               FN_QUERY: begin
                  if (ok) begin
                     res.granted = SLOT_IDX_W'(tgt_ff);
                     res.visible = (rec_cur.phase == PH_READY) ? rec_cur.visible : dflt;
                     res.samples = rec_cur.samples;
                  end else begin
                     res.visible = dflt;
                  end
               end
               FN_NEW_FRAME, FN_CLEAR: begin
                  res.granted = '0;
               end
            endcase

            // Commit once the output register has room
            if (out_free) begin
               done     = 1'b1;
               state_in = SQ_IDLE;
               unique case (func_ff)
                  FN_ALLOC: begin
                     if (ok && alloc_new_ff) begin
                        taken_in[tgt_ff]   = 1'b1;
                        rec_vld_in[tgt_ff] = 1'b1;
                        obj_wr_en          = 1'b1;
                        rec_wr_en          = 1'b1;
                        count_in           = count_ff + COUNT_W'(1);
                     end
                  end
                  FN_ISSUE: begin
                     if (ok) begin
                        rec_wr_en           = 1'b1;
                        rec_vld_in[tgt_ff]  = 1'b1;
                        rec_wr_data.phase   = PH_PENDING;
                        rec_wr_data.visible = rec_cur.visible;
                        rec_wr_data.samples = rec_cur.samples;
                        ev.inc_issue        = 1'b1;
                     end
                  end
                  FN_SUBMIT: begin
                     if (ok) begin
                        rec_wr_en           = 1'b1;
                        rec_vld_in[tgt_ff]  = 1'b1;
                        rec_wr_data.phase   = PH_READY;
                        rec_wr_data.visible = cmp_gt;
                        rec_wr_data.samples = samp_ff;
                        ev.inc_result       = 1'b1;
                        ev.inc_visible      = cmp_gt;
                        ev.inc_occluded     = !cmp_gt;
                     end
                  end
                  FN_FREE_SLOT, FN_FREE_OBJ: begin
                     if (ok) begin
                        if (taken_ff[tgt_ff]) begin
                           taken_in[tgt_ff] = 1'b0;
                           if (count_ff != '0) begin
                              count_in = count_ff - COUNT_W'(1);
                           end
                        end
                        rec_wr_en          = 1'b1;
                        rec_vld_in[tgt_ff] = 1'b1;
                     end
                  end
                  FN_QUERY: begin
                     rec_wr_en = 1'b0;
                  end
                  FN_NEW_FRAME: begin
                     ev.clr_frame = 1'b1;
                  end
                  FN_CLEAR: begin
                     taken_in    = '0;
                     rec_vld_in  = '0;
                     wipe_vis_in = dflt;
                     count_in    = '0;
                     ev.clr_all  = 1'b1;
                  end
               endcase
            end
         end

         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SQ_IDLE;
         cmp_vld_ff  <= 1'b0;
         taken_ff    <= '0;
         rec_vld_ff  <= '0;
         wipe_vis_ff <= 1'b1;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         taken_ff    <= taken_in;
         rec_vld_ff  <= rec_vld_in;
         wipe_vis_ff <= wipe_vis_in;
         count_ff    <= count_in;
      end
   end

   // Item and scan datapath
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      obj_ff       <= obj_in;
      samp_ff      <= samp_in;
      tgt_ff       <= tgt_in;
      status_ff    <= status_in;
      alloc_new_ff <= alloc_new_in;
      scan_ptr_ff  <= scan_ptr_in;
      cmp_ptr_ff   <= cmp_ptr_in;
      free_ok_ff   <= free_ok_in;
      free_ptr_ff  <= free_ptr_in;
   end

   assign busy         = (state_ff != SQ_IDLE);
   assign in_use_count = count_ff;

   `OQSP_ASSERT(a_count_matches, clock, reset, count_ff == COUNT_W'($countones(taken_ff)), "in-use count differs from taken slots")
   `OQSP_ASSERT(a_alloc_untaken, clock, reset, (state_ff == SQ_APPLY && func_ff == FN_ALLOC && ok && alloc_new_ff) |-> !taken_ff[tgt_ff], "allocate claims a taken slot")
   `OQSP_ASSERT(a_compare_in_scan, clock, reset, cmp_vld_ff |-> (state_ff == SQ_SCAN && $past(scan_rd)), "compare without a scan read")

endmodule

### rtl/occlusion_query_slot_pool.sv
// Top level of the occlusion query slot pool: channels, configuration and output register.
//
// Usage:
//  - req_* carries one operation per beat (func, object_id, slot_index, samples). A beat is
//    taken when req_valid is high and req_stall is low; req_stall stays high while an
//    operation is in flight, so one operation is worked on at a time.
//  - rsp_* carries exactly one result beat per operation, taken when rsp_valid is high and
//    rsp_stall is low. The counter fields show the pool state after that operation.
//  - csr_* writes register 0 (visibility threshold) or 1 (conservative default); csr_ready
//    is always high. Write only while no operation is outstanding.
// Work from request beat to result valid:
//  - issue, submit, free slot, new frame, clear: no scan of the object RAM.
//  - allocate, free object, query: the object RAM is scanned one slot per cycle through a
//    single shared comparator, up to a match or the end of the pool.
// Reset: synchronous, clears all slots through per-slot valid bits at once; the pool takes
// a request as soon as reset is released, with no clearing pass.
// A stalled result holds in the output register; the next request is taken meanwhile and
// waits at its last step until the output register empties.
`include "assert_macros.svh"

module occlusion_query_slot_pool #(
   parameter int SLOTS = oqsp_pkg::SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [oqsp_pkg::FUNC_W-1:0]        req_func,
   input  logic [oqsp_pkg::WORD_W-1:0]        req_object_id,
   input  logic [oqsp_pkg::SLOT_IDX_W-1:0]    req_slot_index,
   input  logic [oqsp_pkg::WORD_W-1:0]        req_samples,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [oqsp_pkg::STATUS_W-1:0]      rsp_status,
   output logic [oqsp_pkg::SLOT_IDX_W-1:0]    rsp_granted_slot,
   output logic                               rsp_visible,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_samples_out,
   output logic [oqsp_pkg::COUNT_W-1:0]       rsp_in_use_count,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_frame_issued,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_frame_results,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_issued_total,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_results_total,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_visible_total,
   output logic [oqsp_pkg::WORD_W-1:0]        rsp_occluded_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [oqsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [oqsp_pkg::WORD_W-1:0]        csr_wdata
);

   import oqsp_pkg::*;

   logic [WORD_W-1:0] thresh_ff;
   logic              dflt_ff;
   logic              rsp_valid_ff;
   res_type           res_ff;
   res_type           res;
   evcnt_ctl_type     ev;
   evcnt_val_type     cnt;
   logic              start;
   logic              busy;
   logic              done;
   logic              out_free;
   logic [COUNT_W-1:0] in_use;

   assign start     = req_valid && !req_stall;
   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         dflt_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_THRESHOLD) begin
            thresh_ff <= csr_wdata;
         end else if (csr_index == REG_DEFAULT) begin
            dflt_ff <= csr_wdata[0];
         end
      end
   end

   oqsp_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .func         (req_func),
      .object_id    (req_object_id),
      .slot_index   (req_slot_index),
      .samples      (req_samples),
      .threshold    (thresh_ff),
      .dflt         (dflt_ff),
      .out_free     (out_free),
      .busy         (busy),
      .done         (done),
      .res          (res),
      .ev           (ev),
      .in_use_count (in_use)
   );

   oqsp_evcnt u_evcnt (
      .clock (clock),
      .reset (reset),
      .ev    (ev),
      .cnt   (cnt)
   );

   // Output register: load on completion, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         res_ff <= res;
      end
   end

   // Counters change only when the next result loads, so they drive the beat directly
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = res_ff.status;
   assign rsp_granted_slot   = res_ff.granted;
   assign rsp_visible        = res_ff.visible;
   assign rsp_samples_out    = res_ff.samples;
   assign rsp_in_use_count   = in_use;
   assign rsp_frame_issued   = cnt.frame_issued;
   assign rsp_frame_results  = cnt.frame_results;
   assign rsp_issued_total   = cnt.issued_total;
   assign rsp_results_total  = cnt.results_total;
   assign rsp_visible_total  = cnt.visible_total;
   assign rsp_occluded_total = cnt.occluded_total;

   `OQSP_NEVER(a_no_overwrite, clock, reset, done && rsp_valid_ff && rsp_stall, "result overwrites a stalled beat")

endmodule
